// ----- rtl/core/ipv6_extension_header_walker_assert.svh -----
// Assertion macros for the IPv6 extension header walker checker.
// No dependencies; included by the checker file.
`ifndef IPV6_EXTENSION_HEADER_WALKER_ASSERT_SVH
`define IPV6_EXTENSION_HEADER_WALKER_ASSERT_SVH

// Clocked assertion, off while reset is high.
`define IPV6EH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define IPV6EH_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/ipv6eh_pkg.sv -----
// Shared types, constants and functions of the IPv6 extension header walker.
// No dependencies; compiled first.
`default_nettype none

package ipv6eh_pkg;

   localparam int FIXED_HEADER_BYTES = 40;
   localparam logic [15:0] POS_MAX = 16'hFFFF;
   localparam logic [3:0] MAX_EXT_RESET = 4'd8;

   // next-header codes
   localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
   localparam logic [7:0] NH_ROUTING    = 8'd43;
   localparam logic [7:0] NH_FRAGMENT   = 8'd44;
   localparam logic [7:0] NH_AH         = 8'd51;
   localparam logic [7:0] NH_DEST_OPTS  = 8'd60;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TRUNCATED = 2'd1,
      STATUS_TOO_MANY  = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] byte_offset;
      logic [15:0] header_start;
      logic [7:0]  current_type;
      logic [7:0]  following_type;
      logic [15:0] payload_len;
      logic [3:0]  ext_count;
      logic        chain_done;
      logic [1:0]  error_code;
   } walk_state_type;

   typedef struct packed {
      logic [7:0]  upper_protocol;
      logic [15:0] header_bytes;
      logic [15:0] payload_length;
      status_type  status;
   } walk_result_type;

   function automatic logic is_extension(input logic [7:0] nh);
      return (nh == NH_HOP_BY_HOP) || (nh == NH_DEST_OPTS) || (nh == NH_ROUTING) ||
             (nh == NH_FRAGMENT) || (nh == NH_AH);
   endfunction

   // Header span in bytes from its type and length byte.
   function automatic logic [11:0] span_of(input logic [7:0] nh, input logic [7:0] len);
      logic [8:0] len_p1;
      logic [8:0] len_p2;
      len_p1 = {1'b0, len} + 9'd1;
      len_p2 = {1'b0, len} + 9'd2;
      if (nh == NH_FRAGMENT) begin
         return 12'd8;
      end else if (nh == NH_AH) begin
         return {1'b0, len_p2, 2'b00};
      end else begin
         return {len_p1, 3'b000};
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ipv6eh_req_if.sv -----
// Input channel of the walker: one packet byte per transaction.
// No dependencies.
`default_nettype none

interface ipv6eh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ipv6eh_rsp_if.sv -----
// Result channel of the walker: one transaction per packet.
// No dependencies.
`default_nettype none

interface ipv6eh_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  upper_protocol;
   logic [15:0] header_bytes;
   logic [15:0] payload_length;
   logic [1:0]  status;

   modport source (output valid, output upper_protocol, output header_bytes,
                   output payload_length, output status, input ready);
   modport sink (input valid, input upper_protocol, input header_bytes,
                 input payload_length, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ipv6eh_csr_if.sv -----
// Register write channel of the walker: carries max_ext_headers.
// No dependencies.
`default_nettype none

interface ipv6eh_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] max_ext_headers;

   modport source (output valid, output max_ext_headers, input ready);
   modport sink (input valid, input max_ext_headers, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ipv6eh_step.sv -----
// Per-byte next-state and result logic of the walker.
// Depends on ipv6eh_pkg.
`default_nettype none

module ipv6eh_step
   import ipv6eh_pkg::*;
(
   input  walk_state_type  cur_state,
   input  logic [7:0]      data_byte,
   input  logic            last_byte,
   input  logic [3:0]      max_ext_headers,
   output walk_state_type  next_state,
   output walk_result_type result
);

   walk_state_type nx;
   logic [15:0]    p;
   logic           exact;
   logic           enter;
   logic [11:0]    span;
   logic [16:0]    next_start;
   logic [16:0]    p_plus1;

   always_comb begin
      nx         = cur_state;
      p          = cur_state.byte_offset;
      exact      = (p != POS_MAX);
      enter      = 1'b0;
      span       = span_of(cur_state.current_type, data_byte);
      next_start = {1'b0, cur_state.header_start} + {5'b0, span};
      p_plus1    = {1'b0, p} + 17'd1;

      if (cur_state.header_start == 16'd0) begin
         // fixed header: pick length and first next-header
         if (p == 16'd4) begin
            nx.payload_len[15:8] = data_byte;
         end else if (p == 16'd5) begin
            nx.payload_len[7:0] = data_byte;
         end else if (p == 16'd6) begin
            nx.current_type = data_byte;
         end
         if (p == 16'(FIXED_HEADER_BYTES - 1)) begin
            nx.header_start = 16'(FIXED_HEADER_BYTES);
            enter           = 1'b1;
         end
      end else if (!cur_state.chain_done && exact && cur_state.header_start != POS_MAX) begin
         if (p == cur_state.header_start) begin
            nx.following_type = data_byte;
         end else if (p == cur_state.header_start + 16'd1) begin
            nx.header_start = next_start[16] ? POS_MAX : next_start[15:0];
            nx.current_type = cur_state.following_type;
            nx.ext_count    = cur_state.ext_count + 4'd1;
            enter           = 1'b1;
         end
      end

      if (enter) begin
         if (!is_extension(nx.current_type)) begin
            nx.chain_done = 1'b1;
         end else if (nx.ext_count >= max_ext_headers) begin
            nx.error_code = STATUS_TOO_MANY;
            nx.chain_done = 1'b1;
         end
      end

      if (exact) begin
         nx.byte_offset = p + 16'd1;
      end

      result.upper_protocol = nx.current_type;
      result.header_bytes   = nx.header_start;
      result.payload_length = nx.payload_len;
      if (!nx.chain_done) begin
         result.status = STATUS_TRUNCATED;
      end else if (nx.error_code != STATUS_OK) begin
         result.status = status_type'(nx.error_code);
      end else if (exact && ({1'b0, nx.header_start} > p_plus1)) begin
         // chain ended on a header that starts past the packet end
         result.status = STATUS_TRUNCATED;
      end else begin
         result.status = STATUS_OK;
      end

      // clear the walker after the final byte
      next_state = last_byte ? '0 : nx;
   end

endmodule

`default_nettype wire

// ----- rtl/core/ipv6_extension_header_walker.sv -----
// Channel   Dir  Payload                                             Handshake
// req_ch    in   data_byte[7:0], last_byte                           valid/ready
// rsp_ch    out  upper_protocol, header_bytes, payload_length, status valid/ready
// csr_ch    in   max_ext_headers[3:0]                                valid/ready
//
// One byte per cycle while req_ch.ready is high: each accepted byte updates the walk state in the same cycle.
// The result is registered and appears the cycle after the final byte.
// req_ch.ready is low only while a result waits and rsp_ch.ready is low.
// Synchronous reset clears the walk state and sets max_ext_headers to 8.
// csr_ch.ready is always high.
// Depends on ipv6eh_pkg, the channel interfaces and ipv6eh_step.
`default_nettype none

module ipv6_extension_header_walker
   import ipv6eh_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   ipv6eh_req_if.sink    req_ch,
   ipv6eh_rsp_if.source  rsp_ch,
   ipv6eh_csr_if.sink    csr_ch
);

   walk_state_type  state_ff, state_in;
   walk_result_type result;
   walk_result_type rsp_data_ff;
   logic [3:0]      max_ext_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_accept;

   ipv6eh_step u_step (
      .cur_state       (state_ff),
      .data_byte       (req_ch.data_byte),
      .last_byte       (req_ch.last_byte),
      .max_ext_headers (max_ext_ff),
      .next_state      (state_in),
      .result          (result)
   );

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      if (req_accept && req_ch.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         max_ext_ff   <= MAX_EXT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
         if (csr_ch.valid) begin
            max_ext_ff <= csr_ch.max_ext_headers;
         end
      end
   end

   // hold result payload until the next final byte
   always_ff @(posedge clock) begin
      if (req_accept && req_ch.last_byte) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.upper_protocol = rsp_data_ff.upper_protocol;
   assign rsp_ch.header_bytes   = rsp_data_ff.header_bytes;
   assign rsp_ch.payload_length = rsp_data_ff.payload_length;
   assign rsp_ch.status         = rsp_data_ff.status;

endmodule

`default_nettype wire

// ----- rtl/core/ipv6eh_checker.sv -----
// Port-level checks of the walker, bound to the top level.
// Depends on ipv6_extension_header_walker_assert.svh.
`default_nettype none

`include "ipv6_extension_header_walker_assert.svh"

module ipv6eh_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       req_last,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [1:0] rsp_status
);

   `IPV6EH_ASSERT_ALWAYS(a_idle_after_reset, clock,
                         $past(reset) |-> !rsp_valid, "result valid after reset")
   `IPV6EH_ASSERT(a_rsp_held, clock, reset,
                  rsp_valid && !rsp_ready |=> rsp_valid, "stalled result dropped")
   `IPV6EH_ASSERT(a_last_gives_rsp, clock, reset,
                  req_valid && req_ready && req_last |=> rsp_valid, "final byte gave no result")
   `IPV6EH_ASSERT(a_ready_when_empty, clock, reset,
                  !rsp_valid |-> req_ready, "input stalled with empty output")
   `IPV6EH_ASSERT(a_status_code, clock, reset,
                  rsp_valid |-> rsp_status != 2'd3, "undefined status code")

endmodule

bind ipv6_extension_header_walker ipv6eh_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_last   (req_ch.last_byte),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status)
);

`default_nettype wire
